>>> design/sbapfc_pkg.sv
// Shared types and constants for the switch buffer admission block.
// Holds item structs, operation and register codes, and the counter row type.
// No dependencies.
`timescale 1ns / 1ps

package sbapfc_pkg;

	// Default geometry
	localparam int DEF_PORTS  = 16;
	localparam int DEF_QUEUES = 8;

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int PORT_W   = 4;
	localparam int QUEUE_W  = 3;
	localparam int BYTES_W  = 14;
	localparam int DRAW_W   = 16;
	localparam int CNT_W    = 25;
	localparam int PROB_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = CNT_W;
	// Slot number as computed from the port and queue fields
	localparam int SLOT_CALC_W = PORT_W + QUEUE_W;
	// Width of the marking products
	localparam int PROD_W = DRAW_W + CNT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Reset values of the configuration registers
	localparam logic [CNT_W-1:0]  RST_BUFFER    = CNT_W'(65536);
	localparam logic [CNT_W-1:0]  RST_PAUSE_ON  = CNT_W'(25000);
	localparam logic [CNT_W-1:0]  RST_RESUME    = CNT_W'(20000);
	localparam logic [CNT_W-1:0]  RST_MARK_MIN  = CNT_W'(5000);
	localparam logic [CNT_W-1:0]  RST_MARK_MAX  = CNT_W'(200000);
	localparam logic [PROB_W-1:0] RST_MARK_PROB = PROB_W'(655);

	// Operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ING_ARRIVE = 2'd0,
		FUNC_ING_DEPART = 2'd1,
		FUNC_EGR_ENQ    = 2'd2,
		FUNC_EGR_DEQ    = 2'd3
	} sba_func_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUEUE_BUFFER = 3'd0,
		CFG_PAUSE_ON     = 3'd1,
		CFG_RESUME       = 3'd2,
		CFG_MARK_MIN     = 3'd3,
		CFG_MARK_MAX     = 3'd4,
		CFG_MARK_PROB    = 3'd5
	} sba_cfg_idx_t;

	typedef struct packed {
		sba_func_t            func;
		logic [PORT_W-1:0]    port_num;
		logic [QUEUE_W-1:0]   queue_num;
		logic [BYTES_W-1:0]   pkt_bytes;
		logic [DRAW_W-1:0]    rand_draw;
	} sba_in_t;

	typedef struct packed {
		logic admitted;
		logic send_pause;
		logic send_resume;
		logic ecn_mark;
		logic underflow;
	} sba_out_t;

	// One row of the counter memory
	typedef struct packed {
		logic              pause;
		logic [CNT_W-1:0]  ingress;
		logic [CNT_W-1:0]  egress;
	} sba_row_t;

endpackage

>>> design/switch_buffer_admission_pfc_ecn_core.sv
// Per port and queue buffer admission with pause/resume and ECN marking.
// Each item passes the read, multiply and compare states; its result is registered
// when compare ends, which an output stall can hold off. No new item is taken until
// the last is through the read-modify-write of the counter memory and the two-stage
// marking multiply and compare. Reset: after arst_n releases, a clearing pass zeroes
// the counter memory, during which in_stall is high. Depends on sbapfc_pkg.
`timescale 1ns / 1ps

module switch_buffer_admission_pfc_ecn_core
	import sbapfc_pkg::*;
#(
	parameter int PORTS  = DEF_PORTS,
	parameter int QUEUES = DEF_QUEUES
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  sba_in_t            in_item,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output sba_out_t           out_item,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int SLOTS  = PORTS * QUEUES;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_MUL   = 5'b01000,
		S_CMP   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [CNT_W-1:0]  buffer_q, pause_on_q, resume_q, mark_min_q, mark_max_q;
	logic [PROB_W-1:0] mark_prob_q;
	logic [CNT_W-1:0]  span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q    <= RST_BUFFER;
			pause_on_q  <= RST_PAUSE_ON;
			resume_q    <= RST_RESUME;
			mark_min_q  <= RST_MARK_MIN;
			mark_max_q  <= RST_MARK_MAX;
			mark_prob_q <= RST_MARK_PROB;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUEUE_BUFFER: buffer_q    <= cfg_data;
				CFG_PAUSE_ON:     pause_on_q  <= cfg_data;
				CFG_RESUME:       resume_q    <= cfg_data;
				CFG_MARK_MIN:     mark_min_q  <= cfg_data;
				CFG_MARK_MAX:     mark_max_q  <= cfg_data;
				CFG_MARK_PROB:    mark_prob_q <= cfg_data[PROB_W-1:0];
				default: ;
			endcase
		end
	end

	// Marking span, only consumed when the queue is above mark_min
	always_ff @(posedge clk) begin
		span_q <= mark_max_q - mark_min_q;
	end

	// Input accept and slot decode
	logic accept;
	logic [SLOT_CALC_W-1:0] slot_calc;
	logic [SLOT_W-1:0] slot;
	logic in_range;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign slot_calc = SLOT_CALC_W'(in_item.port_num) * SLOT_CALC_W'(QUEUES)
		+ SLOT_CALC_W'(in_item.queue_num);
	assign in_range = (32'(in_item.port_num) < PORTS) && (32'(in_item.queue_num) < QUEUES);
	assign slot = in_range ? SLOT_W'(slot_calc) : '0;

	// Item captured at accept
	sba_in_t item_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic range_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1  <= in_item;
			slot_s1  <= slot;
			range_s1 <= in_range;
		end
	end

	// Counter memory: one row per slot, read at accept, written back in S_READ if in range
	sba_row_t mem [SLOTS];
	sba_row_t rd_row_q;
	sba_row_t new_row;
	logic [SLOT_W-1:0] clr_addr_q;
	logic mem_we;
	logic [SLOT_W-1:0] mem_wa;
	sba_row_t mem_wd;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_q <= mem[slot];
		end
	end

	assign mem_we = (state_q == S_CLEAR) || ((state_q == S_READ) && range_s1);
	assign mem_wa = (state_q == S_CLEAR) ? clr_addr_q : slot_s1;
	assign mem_wd = (state_q == S_CLEAR) ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Modify: counter updates and threshold checks
	logic [CNT_W:0]   ing_sum, egr_sum;
	logic [CNT_W-1:0] bytes_ext, ing_sub, egr_sub, egr_new;
	logic fits, ing_under, egr_under;
	sba_out_t res_d;
	logic mark_ok_d, above_max_d, above_min_d;
	logic [CNT_W-1:0] diff_d;

	always_comb begin
		bytes_ext = CNT_W'(item_s1.pkt_bytes);
		ing_sum   = {1'b0, rd_row_q.ingress} + {1'b0, bytes_ext};
		egr_sum   = {1'b0, rd_row_q.egress} + {1'b0, bytes_ext};
		fits      = ing_sum <= {1'b0, buffer_q};
		ing_under = bytes_ext > rd_row_q.ingress;
		egr_under = bytes_ext > rd_row_q.egress;
		ing_sub   = ing_under ? '0 : rd_row_q.ingress - bytes_ext;
		egr_sub   = egr_under ? '0 : rd_row_q.egress - bytes_ext;
		egr_new   = egr_sum[CNT_W] ? CNT_MAX : egr_sum[CNT_W-1:0];

		new_row   = rd_row_q;
		res_d     = '0;
		mark_ok_d = 1'b0;
		unique case (item_s1.func)
			FUNC_ING_ARRIVE: begin
				if (fits) begin
					res_d.admitted  = 1'b1;
					new_row.ingress = ing_sum[CNT_W-1:0];
					if (!rd_row_q.pause && ing_sum[CNT_W-1:0] >= pause_on_q) begin
						new_row.pause    = 1'b1;
						res_d.send_pause = 1'b1;
					end
				end
			end
			FUNC_ING_DEPART: begin
				res_d.underflow = ing_under;
				new_row.ingress = ing_sub;
				if (rd_row_q.pause && ing_sub <= resume_q) begin
					new_row.pause     = 1'b0;
					res_d.send_resume = 1'b1;
				end
			end
			FUNC_EGR_ENQ: begin
				new_row.egress = egr_new;
				mark_ok_d      = (item_s1.queue_num != '0);
			end
			FUNC_EGR_DEQ: begin
				res_d.underflow = egr_under;
				new_row.egress  = egr_sub;
			end
		endcase
		if (!range_s1) begin
			res_d     = '0;
			mark_ok_d = 1'b0;
		end
		above_max_d = egr_new > mark_max_q;
		above_min_d = egr_new > mark_min_q;
		diff_d      = egr_new - mark_min_q;
	end

	// Stage 2: flags and marking operand
	sba_out_t res_s2;
	logic mark_ok_s2, above_max_s2, above_min_s2;
	logic [CNT_W-1:0] diff_s2;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			res_s2       <= res_d;
			mark_ok_s2   <= mark_ok_d;
			above_max_s2 <= above_max_d;
			above_min_s2 <= above_min_d;
			diff_s2      <= diff_d;
		end
	end

	// Stage 3: marking products
	logic [PROD_W-1:0] lhs_s3, rhs_s3;

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			lhs_s3 <= PROD_W'(item_s1.rand_draw) * PROD_W'(span_q);
			rhs_s3 <= PROD_W'(mark_prob_q) * PROD_W'(diff_s2);
		end
	end

	// Final mark decision
	sba_out_t res_final;

	always_comb begin
		res_final = res_s2;
		if (mark_ok_s2) begin
			if (above_max_s2) begin
				res_final.ecn_mark = 1'b1;
			end else if (above_min_s2) begin
				res_final.ecn_mark = lhs_s3 < rhs_s3;
			end
		end
	end

	// Output register
	logic out_free;
	logic out_valid_q;
	sba_out_t out_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_CMP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CMP) && out_free) begin
			out_q <= res_final;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + SLOT_W'(1);
					if (clr_addr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_MUL;
				S_MUL:  state_q <= S_CMP;
				S_CMP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> in_stall)
		else $error("input accepted during clearing pass");

	a_read_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_MUL))
		else $error("read stage did not advance to multiply");

	a_pause_resume_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.send_pause && out_q.send_resume))
		else $error("pause and resume in one result");

	a_admit_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.admitted && (out_q.underflow || out_q.ecn_mark)))
		else $error("admitted result carries egress or removal flags");

endmodule

>>> bench/switch_buffer_admission_pfc_ecn_core_tb.sv
// Testbench for switch_buffer_admission_pfc_ecn_core: directed and random packet events,
// checked item by item against a bit-accurate model of the admission, pause and ECN logic.
// Depends on sbapfc_pkg and the core module only.
`timescale 1ns / 1ps

module switch_buffer_admission_pfc_ecn_core_tb
	import sbapfc_pkg::*;
();

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int SLOTS         = DEF_PORTS * DEF_QUEUES;
	localparam int HOT_SLOTS     = 3;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int MAX_PRINTS    = 40;

	// Tracks per-slot byte counts and pause flags, predicts each verdict
	class admission_tracker;
		logic [CNT_W-1:0]  ing_bytes [SLOTS];
		logic [CNT_W-1:0]  egr_bytes [SLOTS];
		bit                paused [SLOTS];
		logic [CNT_W-1:0]  buf_limit, pause_on, resume_at, mark_min, mark_max;
		logic [PROB_W-1:0] mark_prob;
		sba_out_t          pending_verdicts [$];
		int                errors;
		int                seen;

		function new();
			foreach (ing_bytes[i]) begin
				ing_bytes[i] = '0;
				egr_bytes[i] = '0;
				paused[i] = 1'b0;
			end
			buf_limit = RST_BUFFER;
			pause_on  = RST_PAUSE_ON;
			resume_at = RST_RESUME;
			mark_min  = RST_MARK_MIN;
			mark_max  = RST_MARK_MAX;
			mark_prob = RST_MARK_PROB;
			errors = 0;
			seen = 0;
		endfunction

		function void set_register(sba_cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_QUEUE_BUFFER: buf_limit = val;
				CFG_PAUSE_ON:     pause_on = val;
				CFG_RESUME:       resume_at = val;
				CFG_MARK_MIN:     mark_min = val;
				CFG_MARK_MAX:     mark_max = val;
				CFG_MARK_PROB:    mark_prob = val[PROB_W-1:0];
				default: ;
			endcase
		endfunction

		// Applies one packet event to the counters and returns its verdict
		function sba_out_t admit_event(sba_in_t ev);
			sba_out_t          v;
			int unsigned       slot;
			logic [CNT_W:0]    total;
			logic [CNT_W-1:0]  amt;
			logic [PROD_W-1:0] lhs, rhs;
			v = '0;
			slot = ev.port_num * DEF_QUEUES + ev.queue_num;
			amt = CNT_W'(ev.pkt_bytes);
			case (ev.func)
				FUNC_ING_ARRIVE: begin
					total = {1'b0, ing_bytes[slot]} + {1'b0, amt};
					if (total <= {1'b0, buf_limit}) begin
						v.admitted = 1'b1;
						ing_bytes[slot] = total[CNT_W-1:0];
						if (!paused[slot] && ing_bytes[slot] >= pause_on) begin
							paused[slot] = 1'b1;
							v.send_pause = 1'b1;
						end
					end
				end
				FUNC_ING_DEPART: begin
					if (amt > ing_bytes[slot]) begin
						v.underflow = 1'b1;
						ing_bytes[slot] = '0;
					end else begin
						ing_bytes[slot] = ing_bytes[slot] - amt;
					end
					if (paused[slot] && ing_bytes[slot] <= resume_at) begin
						paused[slot] = 1'b0;
						v.send_resume = 1'b1;
					end
				end
				FUNC_EGR_ENQ: begin
					total = {1'b0, egr_bytes[slot]} + {1'b0, amt};
					egr_bytes[slot] = total[CNT_W] ? CNT_MAX : total[CNT_W-1:0];
					// RED-style mark: certain above max, weighted between min and max
					if (ev.queue_num != '0) begin
						if (egr_bytes[slot] > mark_max) begin
							v.ecn_mark = 1'b1;
						end else if (egr_bytes[slot] > mark_min) begin
							lhs = PROD_W'(ev.rand_draw) * PROD_W'(mark_max - mark_min);
							rhs = PROD_W'(mark_prob) * PROD_W'(egr_bytes[slot] - mark_min);
							v.ecn_mark = (lhs < rhs);
						end
					end
				end
				default: begin
					if (amt > egr_bytes[slot]) begin
						v.underflow = 1'b1;
						egr_bytes[slot] = '0;
					end else begin
						egr_bytes[slot] = egr_bytes[slot] - amt;
					end
				end
			endcase
			return v;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_PRINTS)
				$display("%0t mismatch: %s", $realtime, what);
			errors++;
		endtask

		task note_event(sba_in_t ev);
			pending_verdicts.push_back(admit_event(ev));
		endtask

		// Compares one result item with the oldest prediction, field by field
		task check_verdict(sba_out_t got);
			sba_out_t want;
			string    names [5];
			names = '{"underflow", "ecn_mark", "send_resume", "send_pause", "admitted"};
			seen++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending", seen));
			end else begin
				want = pending_verdicts.pop_front();
				for (int b = 0; b < 5; b++) begin
					if (got[b] !== want[b])
						report_mismatch($sformatf("result %0d %s expected %0b got %0b",
							seen, names[b], want[b], got[b]));
				end
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	sba_in_t              in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sba_out_t             out_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	admission_tracker book;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	logic [PORT_W-1:0]  hot_port [HOT_SLOTS];
	logic [QUEUE_W-1:0] hot_queue [HOT_SLOTS];

	switch_buffer_admission_pfc_ecn_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Result side: stall decided at the falling edge, long hold-offs on request
	initial begin : receiver
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Sample accepted results at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_verdict(out_item);
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL switch_buffer_admission_pfc_ecn_core");
		$finish;
	end

	// Offers one item from a falling edge; returns at the falling edge after acceptance
	task automatic send_item(sba_in_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		book.note_event(it);
		@(negedge clk);
	endtask

	task automatic send_fields(sba_func_t f, int port, int queue, int bytes, int draw);
		sba_in_t it;
		it.func = f;
		it.port_num = PORT_W'(port);
		it.queue_num = QUEUE_W'(queue);
		it.pkt_bytes = BYTES_W'(bytes);
		it.rand_draw = DRAW_W'(draw);
		send_item(it);
	endtask

	// Waits until every predicted verdict has been checked, then lets the pipe settle
	task automatic wait_drain();
		while (book.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(sba_cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		book.set_register(idx, val);
		@(negedge clk);
	endtask

	// Threshold sets: fixed ones cover the extremes and inverted marking, others random
	task automatic apply_settings(int which);
		int unsigned s [6];
		case (which)
			0: s = '{40000, 20000, 8000, 3000, 60000, 32768};
			1: s = '{0, 0, 0, 0, 0, 0};
			2: s = '{16777216, 16777216, 16777216, 16777216, 16777216, 65535};
			3: s = '{65536, 30000, 30000, 50000, 10000, 65535};
			4: s = '{60000, 30000, 15000, 20000, 100000, 65535};
			default: begin
				s[0] = $urandom_range(0, 120000);
				s[1] = $urandom_range(0, 90000);
				s[2] = $urandom_range(0, s[1]);
				s[3] = $urandom_range(0, 60000);
				s[4] = $urandom_range(0, 200000);
				s[5] = $urandom_range(0, 65535);
			end
		endcase
		write_reg(CFG_QUEUE_BUFFER, CFG_W'(s[0]));
		write_reg(CFG_PAUSE_ON, CFG_W'(s[1]));
		write_reg(CFG_RESUME, CFG_W'(s[2]));
		write_reg(CFG_MARK_MIN, CFG_W'(s[3]));
		write_reg(CFG_MARK_MAX, CFG_W'(s[4]));
		write_reg(CFG_MARK_PROB, CFG_W'(s[5]));
		cfg_we <= 1'b0;
	endtask

	// A few slots take most of the traffic so counts climb past the thresholds
	task automatic pick_hot_slots();
		for (int i = 0; i < HOT_SLOTS; i++) begin
			hot_port[i] = PORT_W'($urandom_range(0, DEF_PORTS - 1));
			hot_queue[i] = QUEUE_W'($urandom_range(0, DEF_QUEUES - 1));
		end
	endtask

	function automatic sba_in_t draw_event();
		sba_in_t     ev;
		int unsigned r, pick;
		r = $urandom_range(0, 99);
		if (r < 30)
			ev.func = FUNC_ING_ARRIVE;
		else if (r < 55)
			ev.func = FUNC_ING_DEPART;
		else if (r < 80)
			ev.func = FUNC_EGR_ENQ;
		else
			ev.func = FUNC_EGR_DEQ;
		if ($urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, HOT_SLOTS - 1);
			ev.port_num = hot_port[pick];
			ev.queue_num = hot_queue[pick];
		end else begin
			ev.port_num = PORT_W'($urandom_range(0, DEF_PORTS - 1));
			ev.queue_num = QUEUE_W'($urandom_range(0, DEF_QUEUES - 1));
		end
		r = $urandom_range(0, 9);
		if (r < 4)
			ev.pkt_bytes = BYTES_W'($urandom_range(0, 16383));
		else if (r < 8)
			ev.pkt_bytes = BYTES_W'($urandom_range(0, 3000));
		else if (r == 8)
			ev.pkt_bytes = BYTES_W'(16383);
		else
			ev.pkt_bytes = '0;
		ev.rand_draw = DRAW_W'($urandom_range(0, 65535));
		return ev;
	endfunction

	initial begin : stimulus
		book = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items under reset thresholds
		send_idle_pct = 30;
		recv_stall_pct = 56;
		send_fields(FUNC_ING_ARRIVE, 0, 1, 16383, 0);
		send_fields(FUNC_ING_ARRIVE, 0, 1, 16383, 0);     // crosses pause threshold
		send_fields(FUNC_ING_ARRIVE, 0, 1, 16383, 0);
		send_fields(FUNC_ING_ARRIVE, 0, 1, 16383, 0);
		send_fields(FUNC_ING_ARRIVE, 0, 1, 5, 0);         // one byte over buffer
		send_fields(FUNC_ING_ARRIVE, 0, 1, 4, 0);         // exactly fills buffer
		send_fields(FUNC_ING_DEPART, 0, 1, 16383, 0);
		send_fields(FUNC_ING_DEPART, 0, 1, 16383, 0);
		send_fields(FUNC_ING_DEPART, 0, 1, 12770, 0);     // lands on resume threshold
		send_fields(FUNC_ING_DEPART, 0, 1, 16383, 0);     // smaller than the count, no underflow
		send_fields(FUNC_ING_ARRIVE, 15, 7, 0, 65535);
		send_fields(FUNC_EGR_ENQ, 15, 7, 16383, 0);       // weighted mark, draw zero
		send_fields(FUNC_EGR_ENQ, 15, 7, 0, 65535);       // weighted, largest draw
		send_fields(FUNC_EGR_ENQ, 0, 0, 16383, 0);        // queue zero never marks
		send_fields(FUNC_EGR_DEQ, 15, 7, 16383, 0);
		send_fields(FUNC_EGR_DEQ, 15, 7, 1, 0);           // egress underflow
		send_fields(FUNC_ING_DEPART, 9, 2, 0, 0);
		send_fields(FUNC_ING_ARRIVE, 10, 5, 16383, 65535);
		send_fields(FUNC_EGR_DEQ, 0, 0, 0, 0);

		// Random phases, each with its own thresholds and hot slots
		for (int ph = 0; ph < PHASES; ph++) begin
			in_valid <= 1'b0;
			wait_drain();
			if (ph < 4) begin
				send_idle_pct = 30;
				recv_stall_pct = 56;
			end else if (ph < 7) begin
				send_idle_pct = 56;
				recv_stall_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			apply_settings(ph);
			pick_hot_slots();
			// receiver backs off while items keep coming so the input stalls
			if (ph == 2 || ph == 8)
				hold_requests++;
			repeat (PHASE_ITEMS) send_item(draw_event());
		end

		in_valid <= 1'b0;
		wait_drain();
		if (book.errors == 0)
			$display("PASS switch_buffer_admission_pfc_ecn_core");
		else
			$display("FAIL switch_buffer_admission_pfc_ecn_core");
		$finish;
	end

endmodule

>>> files.f
design/sbapfc_pkg.sv
design/switch_buffer_admission_pfc_ecn_core.sv
bench/switch_buffer_admission_pfc_ecn_core_tb.sv
